@@ hw/rtl/sact_pkg.sv @@
// Shared types, codes and constants of the set-associative cache tag lookup.
`default_nettype none

package sact_pkg;

    // Default geometry limits handed to the top level.
    localparam int MAX_WAYS_DEF  = 8;
    localparam int MAX_SETS_DEF  = 64;
    localparam int ADDR_BITS_DEF = 32;

    // Fixed field widths of the streams and registers.
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 112;
    localparam int OUT_PAD_W   = 5;
    localparam int STAMP_W     = 32;
    localparam int COUNT_W     = 32;
    localparam int LFSR_W      = 16;
    localparam int SHIFT_W     = 6;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int OFFSET_W    = 5;
    localparam int SETBITS_W   = 3;
    localparam int WAYBITS_W   = 2;
    localparam int OUT_WAY_W   = 3;
    localparam int OUT_SET_W   = 6;
    localparam int OUT_TAG_W   = 32;

    // Register reset values.
    localparam logic [OFFSET_W-1:0]  OFFSET_BITS_RST = 5'd0;
    localparam logic [SETBITS_W-1:0] SET_BITS_RST    = 3'd3;
    localparam logic [WAYBITS_W-1:0] WAY_BITS_RST    = 2'd0;
    localparam logic                 USE_LRU_RST     = 1'b0;

    // Galois LFSR taps and seed.
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_SET_BITS    = 2'd1,
        CFG_WAY_BITS    = 2'd2,
        CFG_USE_LRU     = 2'd3
    } sact_cfg_t;

    // Lookup sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } sact_state_t;

    // Control of one step of the way compare unit.
    typedef struct packed {
        logic step;
        logic first;
    } sact_step_t;

endpackage

`default_nettype wire

@@ hw/rtl/sact_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sact_scan.sv @@
// Shared way compare unit: tag match and LRU age search, one way per step.
`default_nettype none

module sact_scan #(
    parameter int MAX_WAYS  = sact_pkg::MAX_WAYS_DEF,
    parameter int ADDR_BITS = sact_pkg::ADDR_BITS_DEF
) (
    input  wire logic                                       aclk,
    input  wire sact_pkg::sact_step_t                       ctrl,
    input  wire logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] entry_way,
    input  wire logic                                       entry_valid,
    input  wire logic [ADDR_BITS-1:0]                       entry_tag,
    input  wire logic [sact_pkg::STAMP_W-1:0]               entry_stamp,
    input  wire logic [ADDR_BITS-1:0]                       lookup_tag,
    input  wire logic [sact_pkg::STAMP_W-1:0]               now_stamp,
    output logic                                            hit_found,
    output logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] hit_way,
    output logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] lru_way
);

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    logic                         hit_found_reg;
    logic [WAY_W-1:0]             hit_way_reg;
    logic [sact_pkg::STAMP_W-1:0] best_age_reg;
    logic [WAY_W-1:0]             best_way_reg;
    logic                         match;
    logic [sact_pkg::STAMP_W-1:0] age;

    // The single comparator and age subtractor shared by all ways.
    assign match = entry_valid && (entry_tag == lookup_tag);
    assign age   = now_stamp - entry_stamp;

    // Keep the lowest matching way and the oldest way; ties stay on the lower way.
    always_ff @(posedge aclk) begin
        if (ctrl.step) begin
            if (ctrl.first) begin
                hit_found_reg <= match;
                hit_way_reg   <= entry_way;
                best_age_reg  <= age;
                best_way_reg  <= entry_way;
            end else begin
                if (match && !hit_found_reg) begin
                    hit_found_reg <= 1'b1;
                    hit_way_reg   <= entry_way;
                end
                if (age > best_age_reg) begin
                    best_age_reg <= age;
                    best_way_reg <= entry_way;
                end
            end
        end
    end

    assign hit_found = hit_found_reg;
    assign hit_way   = hit_way_reg;
    assign lru_way   = best_way_reg;

endmodule

`default_nettype wire

@@ hw/rtl/set_assoc_cache_tag_lookup.sv @@
// Top level of the set-associative cache tag lookup with LRU or random replacement.
//
//  Channel   Direction  Payload                                    Handshake
//  s_        in         tdata: address[31:0]                       tvalid/tready
//  m_        out        tdata: hit, filled_empty, way, set_index,  tvalid/tready
//                       tag_value, hit_count, miss_count
//  cfg_      in         cfg_addr register index, cfg_wdata value   cfg_we
//
// A lookup is accepted, then scans the ways in use one way per step through the single
// read port of the tag/stamp RAM and the shared compare unit, then commits: the commit
// writes the RAMs and loads the output register.
// Reset clears per-set row valid flops at once; there is no clearing pass.
// The commit cycle waits while the output register still holds an untaken result.
`default_nettype none

module set_assoc_cache_tag_lookup #(
    parameter int MAX_WAYS  = sact_pkg::MAX_WAYS_DEF,
    parameter int MAX_SETS  = sact_pkg::MAX_SETS_DEF,
    parameter int ADDR_BITS = sact_pkg::ADDR_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input stream. tdata: address[31:0].
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [sact_pkg::S_TDATA_W-1:0]    s_tdata,
    // Result stream. tdata from bit 0 up: hit[0], filled_empty[1], way[4:2],
    // set_index[10:5], tag_value[42:11], hit_count[74:43], miss_count[106:75],
    // zero pad[111:107].
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [sact_pkg::M_TDATA_W-1:0]    m_tdata,
    // Configuration write port.
    input  wire logic                              cfg_we,
    input  wire logic [sact_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [sact_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_SAT  = $clog2(MAX_WAYS + 1) - 1;
    localparam int SET_SAT  = $clog2(MAX_SETS + 1) - 1;
    localparam int ENTRIES  = MAX_SETS * MAX_WAYS;
    localparam int ENTRY_AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ENTRY_W  = ADDR_BITS + sact_pkg::STAMP_W;

    // Configuration registers.
    logic [sact_pkg::OFFSET_W-1:0]  offset_bits_reg;
    logic [sact_pkg::SETBITS_W-1:0] set_bits_reg;
    logic [sact_pkg::WAYBITS_W-1:0] way_bits_reg;
    logic                           use_lru_reg;

    // Sequencer and running state.
    sact_pkg::sact_state_t         state_reg, state_next;
    logic [sact_pkg::STAMP_W-1:0]  clock_reg;
    logic [sact_pkg::LFSR_W-1:0]   lfsr_reg;
    logic [sact_pkg::COUNT_W-1:0]  hits_reg, misses_reg;
    logic [MAX_SETS-1:0]           row_valid_reg;

    // Per-lookup working registers.
    logic [SET_W-1:0]              set_reg;
    logic [ADDR_BITS-1:0]          tag_reg;
    logic [WAY_W-1:0]              cmp_way_reg;
    logic                          first_reg;
    logic [MAX_WAYS-1:0]           vrow_reg;

    // Output register.
    logic                          m_tvalid_reg;
    logic [sact_pkg::M_TDATA_W-1:0] m_data_reg;

    // Combinational signals.
    logic [ADDR_BITS-1:0]          addr;
    logic [sact_pkg::SETBITS_W-1:0] sb_eff;
    logic [sact_pkg::WAYBITS_W-1:0] wb_eff;
    logic [ADDR_BITS-1:0]          addr_off;
    logic [SET_W-1:0]              set_mask;
    logic [SET_W-1:0]              set_comb;
    logic [ADDR_BITS-1:0]          tag_comb;
    logic [WAY_W:0]                ways_cnt;
    logic [WAY_W-1:0]              last_way;
    logic [MAX_WAYS-1:0]           way_mask;
    logic [MAX_WAYS-1:0]           vrow_cur;
    logic [MAX_WAYS-1:0]           inv;
    logic                          any_inv;
    logic [WAY_W-1:0]              first_inv;
    logic [sact_pkg::LFSR_W-1:0]   lfsr_adv;
    logic                          take_random;
    logic [WAY_W-1:0]              way_sel;
    logic                          accept;
    logic                          commit;
    logic                          out_free;
    sact_pkg::sact_step_t          scan_ctrl;
    logic                          hit_found;
    logic [WAY_W-1:0]              hit_way;
    logic [WAY_W-1:0]              lru_way;
    logic [ENTRY_AW-1:0]           entry_raddr;
    logic [ENTRY_AW-1:0]           entry_waddr;
    logic [ENTRY_W-1:0]            entry_rdata;
    logic [SET_W-1:0]              vram_raddr;
    logic [MAX_WAYS-1:0]           vram_rdata;
    logic [MAX_WAYS-1:0]           vram_wdata;
    logic [sact_pkg::COUNT_W-1:0]  hits_next, misses_next;
    logic [sact_pkg::M_TDATA_W-1:0] m_data_next;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg <= sact_pkg::OFFSET_BITS_RST;
            set_bits_reg    <= sact_pkg::SET_BITS_RST;
            way_bits_reg    <= sact_pkg::WAY_BITS_RST;
            use_lru_reg     <= sact_pkg::USE_LRU_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                sact_pkg::CFG_OFFSET_BITS: offset_bits_reg <= cfg_wdata;
                sact_pkg::CFG_SET_BITS:    set_bits_reg    <= cfg_wdata[sact_pkg::SETBITS_W-1:0];
                sact_pkg::CFG_WAY_BITS:    way_bits_reg    <= cfg_wdata[sact_pkg::WAYBITS_W-1:0];
                sact_pkg::CFG_USE_LRU:     use_lru_reg     <= cfg_wdata[0];
                default:                   ;
            endcase
        end
    end

    // Geometry saturated to the storage limits.
    assign sb_eff = (int'(set_bits_reg) > SET_SAT) ? sact_pkg::SETBITS_W'(SET_SAT)
                                                  : set_bits_reg;
    assign wb_eff = (int'(way_bits_reg) > WAY_SAT) ? sact_pkg::WAYBITS_W'(WAY_SAT)
                                                  : way_bits_reg;

    // Address split into set index and tag.
    assign addr     = ADDR_BITS'(s_tdata);
    assign addr_off = addr >> offset_bits_reg;
    assign set_mask = ~({SET_W{1'b1}} << sb_eff);
    assign set_comb = SET_W'(addr_off) & set_mask;
    assign tag_comb = addr >> (sact_pkg::SHIFT_W'(offset_bits_reg)
                               + sact_pkg::SHIFT_W'(sb_eff));

    // Ways in use.
    assign ways_cnt = (WAY_W + 1)'(1) << wb_eff;
    assign last_way = WAY_W'(ways_cnt - (WAY_W + 1)'(1));
    assign way_mask = ~({MAX_WAYS{1'b1}} << ways_cnt);

    // Valid row of the set: a row never written since reset reads as empty.
    assign vrow_cur = first_reg ? (row_valid_reg[set_reg] ? vram_rdata : '0) : vrow_reg;

    // Lowest empty way among the ways in use.
    assign inv     = ~vrow_reg & way_mask;
    assign any_inv = |inv;
    always_comb begin
        first_inv = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (inv[i]) begin
                first_inv = WAY_W'(i);
            end
        end
    end

    // Next LFSR value for random replacement.
    assign lfsr_adv = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? sact_pkg::LFSR_TAPS : '0);

    // Way choice at commit.
    always_comb begin
        take_random = 1'b0;
        priority if (hit_found) begin
            way_sel = hit_way;
        end else if (any_inv) begin
            way_sel = first_inv;
        end else if (use_lru_reg) begin
            way_sel = lru_way;
        end else begin
            way_sel     = WAY_W'(lfsr_adv) & last_way;
            take_random = 1'b1;
        end
    end

    // Sequencer.
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        s_tready        = 1'b0;
        accept          = 1'b0;
        commit          = 1'b0;
        scan_ctrl.step  = 1'b0;
        scan_ctrl.first = first_reg;
        unique case (state_reg)
            sact_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    accept     = 1'b1;
                    state_next = sact_pkg::ST_SCAN;
                end
            end
            sact_pkg::ST_SCAN: begin
                scan_ctrl.step = 1'b1;
                if (cmp_way_reg == last_way) begin
                    state_next = sact_pkg::ST_FINISH;
                end
            end
            sact_pkg::ST_FINISH: begin
                if (out_free) begin
                    commit     = 1'b1;
                    state_next = sact_pkg::ST_IDLE;
                end
            end
            default: state_next = sact_pkg::ST_IDLE;
        endcase
    end

    // RAM addressing: first way read at accept, then one way ahead of the compare.
    always_comb begin
        if (state_reg == sact_pkg::ST_IDLE) begin
            entry_raddr = ENTRY_AW'(set_comb) * ENTRY_AW'(MAX_WAYS);
        end else begin
            entry_raddr = ENTRY_AW'(set_reg) * ENTRY_AW'(MAX_WAYS)
                          + ENTRY_AW'(WAY_W'(cmp_way_reg + WAY_W'(1)));
        end
    end
    assign vram_raddr  = set_comb;
    assign entry_waddr = ENTRY_AW'(set_reg) * ENTRY_AW'(MAX_WAYS) + ENTRY_AW'(way_sel);
    assign vram_wdata  = vrow_reg | (MAX_WAYS'(1) << way_sel);

    // Tag and age stamp store, one entry per set and way.
    sact_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (commit),
        .waddr (entry_waddr),
        .wdata ({clock_reg, tag_reg}),
        .raddr (entry_raddr),
        .rdata (entry_rdata)
    );

    // Valid bits, one row per set.
    sact_ram #(
        .WIDTH (MAX_WAYS),
        .DEPTH (MAX_SETS)
    ) u_valid_ram (
        .aclk  (aclk),
        .we    (commit),
        .waddr (set_reg),
        .wdata (vram_wdata),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    // Shared compare unit.
    sact_scan #(
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_scan (
        .aclk        (aclk),
        .ctrl        (scan_ctrl),
        .entry_way   (cmp_way_reg),
        .entry_valid (vrow_cur[cmp_way_reg]),
        .entry_tag   (entry_rdata[ADDR_BITS-1:0]),
        .entry_stamp (entry_rdata[ENTRY_W-1:ADDR_BITS]),
        .lookup_tag  (tag_reg),
        .now_stamp   (clock_reg),
        .hit_found   (hit_found),
        .hit_way     (hit_way),
        .lru_way     (lru_way)
    );

    // Running counts and packed result.
    assign hits_next   = hit_found ? hits_reg + sact_pkg::COUNT_W'(1) : hits_reg;
    assign misses_next = hit_found ? misses_reg : misses_reg + sact_pkg::COUNT_W'(1);
    assign m_data_next = {
        {sact_pkg::OUT_PAD_W{1'b0}},
        misses_next,
        hits_next,
        sact_pkg::OUT_TAG_W'(tag_reg),
        sact_pkg::OUT_SET_W'(set_reg),
        sact_pkg::OUT_WAY_W'(way_sel),
        !hit_found && any_inv,
        hit_found
    };

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sact_pkg::ST_IDLE;
            clock_reg     <= '0;
            lfsr_reg      <= sact_pkg::LFSR_SEED;
            hits_reg      <= '0;
            misses_reg    <= '0;
            row_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                clock_reg <= clock_reg + sact_pkg::STAMP_W'(1);
            end
            if (commit) begin
                hits_reg               <= hits_next;
                misses_reg             <= misses_next;
                row_valid_reg[set_reg] <= 1'b1;
                if (take_random) begin
                    lfsr_reg <= lfsr_adv;
                end
            end
            if (commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Per-lookup payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            set_reg     <= set_comb;
            tag_reg     <= tag_comb;
            cmp_way_reg <= '0;
            first_reg   <= 1'b1;
        end else if (scan_ctrl.step) begin
            cmp_way_reg <= cmp_way_reg + WAY_W'(1);
            first_reg   <= 1'b0;
            vrow_reg    <= vrow_cur;
        end
        if (commit) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // Every commit adds exactly one access to the hit and miss totals.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> (hits_reg + misses_reg) == ($past(hits_reg) + $past(misses_reg)
                                               + sact_pkg::COUNT_W'(1)))
        else $error("hit and miss totals did not advance by one access");

    // A committed set reads back through its valid row afterwards.
    a_row_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> row_valid_reg[$past(set_reg)])
        else $error("row valid flag not set after commit");

    // The commit cycle holds while the previous result is still waiting.
    a_commit_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sact_pkg::ST_FINISH) && m_tvalid_reg && !m_tready
        |=> (state_reg == sact_pkg::ST_FINISH) && $stable(m_data_reg))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

@@ tb/set_assoc_cache_tag_lookup_test.sv @@
// Self-checking testbench for the set-associative cache tag lookup.
module set_assoc_cache_tag_lookup_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WAYS_MAX       = 8;
    localparam int SETS_MAX       = 64;
    localparam int SET_BITS_MAX   = 6;
    localparam int GAP_MAX        = 17;
    localparam int HOLD_CYCLES    = 400;
    localparam int STALL_LIMIT    = 3000;
    localparam int END_PAUSE      = 16;
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_LOOKUPS  = 95;
    localparam int SHOWN_ERRORS   = 10;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    // One result as it appears on m_tdata, most significant field first.
    typedef struct packed {
        logic [4:0]  pad;
        logic [31:0] misses;
        logic [31:0] hits;
        logic [31:0] tag;
        logic [5:0]  set_idx;
        logic [2:0]  way;
        logic        filled;
        logic        hit;
    } lookup_result_t;

    typedef enum {ROW_WRITE, ROW_LOOKUP} row_kind_t;

    // One line of the directed stimulus table.
    typedef struct {
        row_kind_t           kind;
        sact_pkg::sact_cfg_t reg_idx;
        logic [4:0]          value;
        logic [31:0]         addr;
        bit                  typed;
        lookup_result_t      want;
    } stim_row_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [sact_pkg::S_TDATA_W-1:0]  s_tdata   = '0;   // address[31:0]
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    // hit[0], filled_empty[1], way[4:2], set_index[10:5], tag_value[42:11],
    // hit_count[74:43], miss_count[106:75], zero pad[111:107]
    logic [sact_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            cfg_we    = 1'b0;
    logic [sact_pkg::CFG_ADDR_W-1:0] cfg_addr  = sact_pkg::CFG_OFFSET_BITS;
    logic [sact_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow geometry and replacement state of the predictor.
    logic [4:0]  geo_offset   = 5'd0;
    logic [2:0]  geo_set_bits = 3'd3;
    logic [1:0]  geo_way_bits = 2'd0;
    logic        geo_lru      = 1'b0;
    bit          line_valid [SETS_MAX*WAYS_MAX];
    logic [31:0] line_tag   [SETS_MAX*WAYS_MAX];
    logic [31:0] line_stamp [SETS_MAX*WAYS_MAX];
    logic [31:0] access_clock = '0;
    logic [15:0] victim_lfsr  = 16'h0001;
    logic [31:0] pred_hits    = '0;
    logic [31:0] pred_misses  = '0;

    lookup_result_t pending_results [$];
    stim_row_t      stim_table [$];
    int  error_count   = 0;
    int  lookups_sent  = 0;
    int  settings_used = 0;
    int  stall_cycles  = 0;
    bit  no_idle       = 1'b0;
    bit  hold_off_req  = 1'b0;

    set_assoc_cache_tag_lookup dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Free-running clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog on cycles in which no transaction and no register write happens.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Idle cycles before the next transaction on either side.
    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    // Looks one address up in the shadow tag store and updates it.
    function automatic lookup_result_t predict_lookup(logic [31:0] addr);
        lookup_result_t res;
        int unsigned sb;
        int unsigned nways;
        int unsigned set_no;
        int unsigned slot;
        int unsigned pick;
        logic [31:0] tag;
        logic [31:0] oldest;
        bit          done;
        res    = '0;
        sb     = (geo_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : geo_set_bits;
        nways  = 1 << geo_way_bits;
        set_no = int'((64'(addr) >> geo_offset) & ((64'd1 << sb) - 1));
        tag    = 32'(64'(addr) >> (geo_offset + sb));
        slot   = set_no * WAYS_MAX;
        access_clock = access_clock + 32'd1;
        done = 1'b0;
        pick = 0;

        // A valid way with a matching tag wins first.
        for (int w = 0; w < nways && !done; w++) begin
            if (line_valid[slot + w] && line_tag[slot + w] == tag) begin
                pick    = w;
                res.hit = 1'b1;
                done    = 1'b1;
            end
        end
        // Otherwise the lowest empty way is filled.
        for (int w = 0; w < nways && !done; w++) begin
            if (!line_valid[slot + w]) begin
                pick       = w;
                res.filled = 1'b1;
                done       = 1'b1;
            end
        end
        // A full set evicts the oldest way or one picked by the LFSR.
        if (!done) begin
            if (geo_lru) begin
                oldest = access_clock - line_stamp[slot];
                for (int w = 1; w < nways; w++) begin
                    if (32'(access_clock - line_stamp[slot + w]) > oldest) begin
                        oldest = access_clock - line_stamp[slot + w];
                        pick   = w;
                    end
                end
            end else begin
                victim_lfsr = {1'b0, victim_lfsr[15:1]} ^ (victim_lfsr[0] ? LFSR_MASK : 16'h0);
                pick = victim_lfsr & (nways - 1);
            end
        end

        if (res.hit) begin
            pred_hits = pred_hits + 32'd1;
        end else begin
            pred_misses = pred_misses + 32'd1;
            line_valid[slot + pick] = 1'b1;
            line_tag[slot + pick]   = tag;
        end
        line_stamp[slot + pick] = access_clock;

        res.way     = 3'(pick);
        res.set_idx = 6'(set_no);
        res.tag     = tag;
        res.hits    = pred_hits;
        res.misses  = pred_misses;
        return res;
    endfunction

    function automatic void add_write(sact_pkg::sact_cfg_t idx, logic [4:0] val);
        stim_table.push_back('{ROW_WRITE, idx, val, 32'h0, 1'b0, lookup_result_t'('0)});
    endfunction

    function automatic void add_lookup(logic [31:0] addr);
        stim_table.push_back('{ROW_LOOKUP, sact_pkg::CFG_OFFSET_BITS, 5'd0, addr, 1'b0,
                               lookup_result_t'('0)});
    endfunction

    function automatic void add_checked(logic [31:0] addr, lookup_result_t want);
        stim_table.push_back('{ROW_LOOKUP, sact_pkg::CFG_OFFSET_BITS, 5'd0, addr, 1'b1,
                               want});
    endfunction

    // Offers one address and queues its expected result once it is taken.
    task automatic send_lookup(logic [31:0] addr, bit typed, lookup_result_t typed_want);
        int gap;
        lookup_result_t want;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        want = predict_lookup(addr);
        if (typed) begin
            want = typed_want;
        end
        pending_results.push_back(want);
        lookups_sent++;
    endtask

    // Stops offering and waits until every queued result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Writes one register; the caller has drained the block first.
    task automatic write_reg(sact_pkg::sact_cfg_t idx, logic [4:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            sact_pkg::CFG_OFFSET_BITS: geo_offset   = val;
            sact_pkg::CFG_SET_BITS:    geo_set_bits = val[2:0];
            sact_pkg::CFG_WAY_BITS:    geo_way_bits = val[1:0];
            sact_pkg::CFG_USE_LRU:     geo_lru      = val[0];
            default:                   ;
        endcase
        @(posedge aclk);
    endtask

    task automatic report_mismatch(string why, lookup_result_t want, lookup_result_t got);
        error_count++;
        if (error_count <= SHOWN_ERRORS) begin
            $display("%s: expected hit=%0d filled=%0d way=%0d set=%0d tag=%h hits=%0d misses=%0d",
                     why, want.hit, want.filled, want.way, want.set_idx, want.tag,
                     want.hits, want.misses);
            $display("    got hit=%0d filled=%0d way=%0d set=%0d tag=%h hits=%0d misses=%0d pad=%0d",
                     got.hit, got.filled, got.way, got.set_idx, got.tag, got.hits,
                     got.misses, got.pad);
        end
    endtask

    // Result side: random back-pressure, one long hold-off on request, checking.
    initial begin : result_sink
        int n;
        lookup_result_t got;
        lookup_result_t want;
        wait (aresetn === 1'b1);
        forever begin
            n = draw_gap();
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                n = HOLD_CYCLES;
            end
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) @(posedge aclk);
            got = lookup_result_t'(m_tdata);
            if (pending_results.size() == 0) begin
                report_mismatch("Result with no lookup pending", lookup_result_t'('0), got);
            end else begin
                want = pending_results.pop_front();
                if (got.hit !== want.hit || got.filled !== want.filled ||
                    got.way !== want.way || got.set_idx !== want.set_idx ||
                    got.tag !== want.tag || got.hits !== want.hits ||
                    got.misses !== want.misses || got.pad !== want.pad) begin
                    report_mismatch("Lookup result mismatch", want, got);
                end
            end
        end
    end

    // Stimulus: directed table, then randomized geometry phases.
    initial begin : stimulus
        int unsigned eff_sb;
        int unsigned nways;
        logic [31:0] tag_base;
        int unsigned set_base;
        logic [31:0] tag_pick;
        int unsigned set_pick;
        logic [63:0] addr64;
        logic [31:0] addr;
        logic [4:0]  off_sel;
        logic [2:0]  set_sel;
        logic [1:0]  way_sel;
        logic        lru_sel;

        line_valid = '{default: 1'b0};
        line_tag   = '{default: 32'h0};
        line_stamp = '{default: 32'h0};

        // Reset defaults: one way, eight sets, no offset, LFSR replacement.
        add_checked(32'h0000_0000, '{pad: 5'd0, misses: 32'd1, hits: 32'd0, tag: 32'h0,
                    set_idx: 6'd0, way: 3'd0, filled: 1'b1, hit: 1'b0});
        add_checked(32'h0000_0000, '{pad: 5'd0, misses: 32'd1, hits: 32'd1, tag: 32'h0,
                    set_idx: 6'd0, way: 3'd0, filled: 1'b0, hit: 1'b1});
        add_checked(32'hFFFF_FFFF, '{pad: 5'd0, misses: 32'd2, hits: 32'd1,
                    tag: 32'h1FFF_FFFF, set_idx: 6'd7, way: 3'd0, filled: 1'b1, hit: 1'b0});
        add_lookup(32'h0000_0008);
        // Oversized set count saturates; eight ways, LRU, 16-unit blocks.
        add_write(sact_pkg::CFG_SET_BITS, 5'd7);
        add_write(sact_pkg::CFG_WAY_BITS, 5'd3);
        add_write(sact_pkg::CFG_USE_LRU, 5'd1);
        add_write(sact_pkg::CFG_OFFSET_BITS, 5'd4);
        for (int t = 0; t < 8; t++) begin
            add_lookup(32'(t * 1024 + 'h50));
        end
        add_lookup(32'h0000_0850);
        add_lookup(32'h0000_2050);
        add_lookup(32'h0000_2450);
        // Same full set under random replacement.
        add_write(sact_pkg::CFG_USE_LRU, 5'd0);
        add_lookup(32'h0000_2850);
        add_lookup(32'h0000_2C50);
        // Widest offset, no set bits, one way: entries read under a new geometry.
        add_write(sact_pkg::CFG_OFFSET_BITS, 5'd31);
        add_write(sact_pkg::CFG_SET_BITS, 5'd0);
        add_write(sact_pkg::CFG_WAY_BITS, 5'd0);
        add_lookup(32'hFFFF_FFFF);
        add_lookup(32'h7FFF_FFFF);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_WRITE) begin
                wait_drained();
                write_reg(stim_table[i].reg_idx, stim_table[i].value);
                settings_used++;
            end else begin
                send_lookup(stim_table[i].addr, stim_table[i].typed, stim_table[i].want);
            end
        end

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            // Geometry of this phase; the first three pin the extremes.
            case (phase)
                0: begin off_sel = 5'd2;  set_sel = 3'd7; way_sel = 2'd3; lru_sel = 1'b1; end
                1: begin off_sel = 5'd31; set_sel = 3'd0; way_sel = 2'd3; lru_sel = 1'b0; end
                2: begin off_sel = 5'd0;  set_sel = 3'd6; way_sel = 2'd0; lru_sel = 1'b1; end
                default: begin
                    off_sel = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                          : 5'($urandom_range(0, 6));
                    set_sel = 3'($urandom_range(0, 7));
                    way_sel = 2'($urandom_range(0, 3));
                    lru_sel = 1'($urandom_range(0, 1));
                end
            endcase
            wait_drained();
            write_reg(sact_pkg::CFG_OFFSET_BITS, off_sel);
            write_reg(sact_pkg::CFG_SET_BITS, 5'(set_sel));
            write_reg(sact_pkg::CFG_WAY_BITS, 5'(way_sel));
            write_reg(sact_pkg::CFG_USE_LRU, 5'(lru_sel));
            settings_used++;

            no_idle = (phase % 4 == 3);
            // Long output hold-off while the input keeps offering.
            if (phase == 5) begin
                no_idle      = 1'b1;
                hold_off_req = 1'b1;
            end

            eff_sb   = (geo_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : geo_set_bits;
            nways    = 1 << geo_way_bits;
            tag_base = $urandom;
            set_base = $urandom_range(0, SETS_MAX - 1);

            // Mostly a small pool of tags over a few sets, some fully random noise.
            for (int i = 0; i < PHASE_LOOKUPS; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    addr = $urandom;
                end else begin
                    tag_pick = tag_base + 32'($urandom_range(0, nways + 2));
                    set_pick = (set_base + $urandom_range(0, 2)) & ((1 << eff_sb) - 1);
                    addr64 = (64'(tag_pick) << (geo_offset + eff_sb))
                           | (64'(set_pick) << geo_offset)
                           | (64'($urandom) & ((64'd1 << geo_offset) - 1));
                    addr = addr64[31:0];
                end
                send_lookup(addr, 1'b0, lookup_result_t'('0));
            end
        end

        no_idle = 1'b0;
        wait_drained();
        repeat (END_PAUSE) @(posedge aclk);

        $display("Checked %0d lookups (%0d hits, %0d misses) over %0d register settings,",
                 lookups_sent, pred_hits, pred_misses, settings_used);
        $display("with LRU and random replacement, saturated geometry and a long output stall.");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
